@@ rtl/srpq_pkg.sv @@
// Shared definitions for the shared ring packet queue: sizes, codes and the
// command record passed from the front end to the ring engine.
// No dependencies.
package srpq_pkg;

   // Ring geometry (ring size must be a power of two).
   localparam int RING_WORDS       = 1024;
   localparam int MAX_PACKET_WORDS = 64;
   localparam int IDX_W            = $clog2(RING_WORDS);
   localparam int CNT_W            = $clog2(MAX_PACKET_WORDS) + 1;
   localparam int RING_BYTES       = RING_WORDS * 4;
   localparam int MAX_PACKET_BYTES = MAX_PACKET_WORDS * 4;

   // Operation codes carried in the request tuser.
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   // Result status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_INVALID = 3'd2;
   localparam logic [2:0] ST_EMPTY   = 3'd3;
   localparam logic [2:0] ST_BADMSG  = 3'd4;

   // One classified request word.
   typedef struct packed {
      logic             opcode;
      logic [31:0]      word;
      logic             hdr_bad;  // word is not a legal header size
      logic [IDX_W:0]   nwords;   // header size in words, valid when hdr_bad is low
   } cmd_type;

endpackage

@@ rtl/srpq_front.sv @@
// Front end of the shared ring packet queue: accepts request words, classifies
// them as header candidates and holds them in a two-entry queue.
// Depends on srpq_pkg.
module srpq_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [31:0]      req_tdata,
   input  logic             req_tuser,
   output srpq_pkg::cmd_type cmd,
   output logic             cmd_valid,
   input  logic             cmd_pop
);

   srpq_pkg::cmd_type q_ff [2];
   logic              head_ff, head_in;
   logic              tail_ff, tail_in;
   logic [1:0]        count_ff, count_in;
   srpq_pkg::cmd_type incoming;
   logic              push;

   // Classify the incoming word as if it were a packet header.
   always_comb begin
      incoming.opcode  = req_tuser;
      incoming.word    = req_tdata;
      incoming.hdr_bad = (req_tdata == 32'd0)
                      || (req_tdata > 32'(srpq_pkg::RING_BYTES))
                      || (req_tdata[1:0] != 2'b00);
      incoming.nwords  = req_tdata[srpq_pkg::IDX_W+2:2];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = q_ff[head_ff];

   // Queue pointers.
   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      if (push) begin
         tail_in = ~tail_ff;
      end
      if (cmd_pop) begin
         head_in = ~head_ff;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && cmd_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= 1'b0;
         tail_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[tail_ff] <= incoming;
      end
   end

endmodule

@@ rtl/srpq_engine.sv @@
// Back end of the shared ring packet queue: the word ring, its indices, the
// write and read sequencing and the result register.
// Depends on srpq_pkg.
module srpq_engine (
   input  logic                     clock,
   input  logic                     reset,
   input  srpq_pkg::cmd_type        cmd,
   input  logic                     cmd_valid,
   output logic                     cmd_pop,
   input  logic                     csr_valid,
   input  logic                     csr_data,
   output logic                     out_valid,
   input  logic                     out_ready,
   output logic [31:0]              out_word,
   output logic                     out_last,
   output logic [2:0]               out_status,
   output logic                     out_tx,
   output logic                     out_rx
);

   localparam int IW = srpq_pkg::IDX_W;
   localparam int CW = srpq_pkg::CNT_W;

   localparam logic S_IDLE    = 1'b0;
   localparam logic S_RD_WORD = 1'b1;

   // Ring memory.
   logic [31:0]   ring_mem [srpq_pkg::RING_WORDS];
   logic [31:0]   rd_data_ff;
   logic          mem_wr, mem_rd;
   logic [IW-1:0] wr_addr, rd_addr;

   // Control state.
   logic          state_ff, state_in;
   logic [IW-1:0] read_idx_ff, read_idx_in;
   logic [IW-1:0] write_idx_ff, write_idx_in;
   logic [IW-1:0] fill_ff, fill_in;
   logic [IW:0]   words_left_ff, words_left_in;
   logic          dropping_ff, dropping_in;
   logic          tx_ff, tx_in;
   logic          rx_ff, rx_in;
   logic          qmsg_ff;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] count_ff, count_in;

   // Result register.
   logic          ov_ff, ov_in;
   logic [31:0]   ow_ff, ow_in;
   logic          ol_ff, ol_in;
   logic [2:0]    os_ff, os_in;
   logic          out_free;
   logic          emit;

   // Helpers.
   logic [IW-1:0] used;
   logic [IW:0]   free_words;
   logic [IW:0]   wl_dec;
   logic [CW+1:0] cnt_sum;
   logic [CW-1:0] hdr_count;
   logic [CW-1:0] k_next;

   assign out_free   = !ov_ff || out_ready;
   assign used       = write_idx_ff - read_idx_ff;
   assign free_words = (IW+1)'(srpq_pkg::RING_WORDS) - {1'b0, used};
   assign wl_dec     = words_left_ff - (IW+1)'(1);
   assign cnt_sum    = rd_data_ff[CW+1:0] + (CW+2)'(3);
   assign hdr_count  = cnt_sum[CW+1:2];
   assign k_next     = k_ff + CW'(1);

   // Command sequencing.
   always_comb begin
      state_in      = state_ff;
      read_idx_in   = read_idx_ff;
      write_idx_in  = write_idx_ff;
      fill_in       = fill_ff;
      words_left_in = words_left_ff;
      dropping_in   = dropping_ff;
      tx_in         = tx_ff;
      rx_in         = rx_ff;
      k_in          = k_ff;
      count_in      = count_ff;
      cmd_pop       = 1'b0;
      mem_wr        = 1'b0;
      wr_addr       = fill_ff;
      mem_rd        = 1'b0;
      rd_addr       = read_idx_ff;
      emit          = 1'b0;
      ow_in         = 32'd0;
      ol_in         = 1'b1;
      os_in         = srpq_pkg::ST_OK;

      unique case (state_ff)
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_pop = 1'b1;
               if (cmd.opcode == srpq_pkg::OP_WRITE) begin
                  if (words_left_ff != '0) begin
                     // Body word of a packet in flight.
                     words_left_in = wl_dec;
                     if (dropping_ff) begin
                        if (wl_dec == '0) begin
                           dropping_in = 1'b0;
                        end
                     end else begin
                        mem_wr  = 1'b1;
                        wr_addr = fill_ff;
                        fill_in = fill_ff + IW'(1);
                        if (wl_dec == '0) begin
                           write_idx_in = fill_ff + IW'(1);
                           emit         = 1'b1;
                        end
                     end
                  end else if (cmd.hdr_bad) begin
                     emit  = 1'b1;
                     os_in = srpq_pkg::ST_INVALID;
                  end else if (free_words <= cmd.nwords) begin
                     // Not enough room: refuse and swallow the rest.
                     tx_in         = 1'b1;
                     words_left_in = cmd.nwords - (IW+1)'(1);
                     dropping_in   = (cmd.nwords != (IW+1)'(1));
                     emit          = 1'b1;
                     os_in         = srpq_pkg::ST_NOSPACE;
                  end else begin
                     // Header accepted and stored.
                     tx_in         = 1'b0;
                     mem_wr        = 1'b1;
                     wr_addr       = write_idx_ff;
                     fill_in       = write_idx_ff + IW'(1);
                     words_left_in = cmd.nwords - (IW+1)'(1);
                     dropping_in   = 1'b0;
                     if (cmd.nwords == (IW+1)'(1)) begin
                        write_idx_in = write_idx_ff + IW'(1);
                        emit         = 1'b1;
                     end
                  end
               end else begin
                  if (read_idx_ff == write_idx_ff) begin
                     rx_in = qmsg_ff;
                     emit  = 1'b1;
                     os_in = srpq_pkg::ST_EMPTY;
                  end else begin
                     // Fetch the header word.
                     mem_rd   = 1'b1;
                     rd_addr  = read_idx_ff;
                     k_in     = '0;
                     state_in = S_RD_WORD;
                  end
               end
            end
         end
         S_RD_WORD: begin
            if (out_free) begin
               emit = 1'b1;
               if (k_ff == '0) begin
                  if (rd_data_ff == 32'd0) begin
                     os_in    = srpq_pkg::ST_INVALID;
                     state_in = S_IDLE;
                  end else if (rd_data_ff > 32'(srpq_pkg::MAX_PACKET_BYTES)) begin
                     read_idx_in = write_idx_ff;
                     rx_in       = qmsg_ff;
                     os_in       = srpq_pkg::ST_BADMSG;
                     state_in    = S_IDLE;
                  end else begin
                     rx_in    = qmsg_ff;
                     ow_in    = rd_data_ff;
                     count_in = hdr_count;
                     ol_in    = (hdr_count == CW'(1));
                     if (hdr_count == CW'(1)) begin
                        read_idx_in = read_idx_ff + IW'(1);
                        state_in    = S_IDLE;
                     end else begin
                        mem_rd  = 1'b1;
                        rd_addr = read_idx_ff + IW'(1);
                        k_in    = CW'(1);
                     end
                  end
               end else begin
                  ow_in = rd_data_ff;
                  ol_in = (k_next == count_ff);
                  if (k_next == count_ff) begin
                     read_idx_in = read_idx_ff + IW'(count_ff);
                     state_in    = S_IDLE;
                  end else begin
                     mem_rd  = 1'b1;
                     rd_addr = read_idx_ff + IW'(k_next);
                     k_in    = k_next;
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Result register next value.
   always_comb begin
      ov_in = ov_ff;
      if (emit) begin
         ov_in = 1'b1;
      end else if (out_ready) begin
         ov_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         read_idx_ff   <= '0;
         write_idx_ff  <= '0;
         fill_ff       <= '0;
         words_left_ff <= '0;
         dropping_ff   <= 1'b0;
         tx_ff         <= 1'b0;
         rx_ff         <= 1'b1;
         qmsg_ff       <= 1'b1;
         k_ff          <= '0;
         count_ff      <= '0;
         ov_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_idx_ff   <= read_idx_in;
         write_idx_ff  <= write_idx_in;
         fill_ff       <= fill_in;
         words_left_ff <= words_left_in;
         dropping_ff   <= dropping_in;
         tx_ff         <= tx_in;
         rx_ff         <= rx_in;
         k_ff          <= k_in;
         count_ff      <= count_in;
         ov_ff         <= ov_in;
         if (csr_valid) begin
            qmsg_ff <= csr_data;
         end
      end
   end

   // Result payload; flags are shown as updated by the item itself.
   always_ff @(posedge clock) begin
      if (emit) begin
         ow_ff  <= ow_in;
         ol_ff  <= ol_in;
         os_ff  <= os_in;
         out_tx <= tx_in;
         out_rx <= rx_in;
      end
   end

   // Ring memory, one access per cycle.
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         ring_mem[wr_addr] <= cmd.word;
      end
      if (mem_rd) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   assign out_valid  = ov_ff;
   assign out_word   = ow_ff;
   assign out_last   = ol_ff;
   assign out_status = os_ff;

   // A refused packet is being dropped only while words are still expected.
   assert property (@(posedge clock) disable iff (reset)
      dropping_ff |-> (words_left_ff != '0))
      else $error("dropping set with no words left");

   // The word counter of a read never reaches the packet length.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_RD_WORD && k_ff != '0) |-> (k_ff < count_ff))
      else $error("read word counter past packet length");

   // Commands are only taken when the result register can accept a word.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> (out_free && state_ff == S_IDLE))
      else $error("command popped while result register busy");

   // Only packet data words may be followed by more results of the same item.
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !ol_ff) |-> (os_ff == srpq_pkg::ST_OK))
      else $error("non-last result with error status");

   // A pending result that is not taken stays unchanged.
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_ready) |=> (ov_ff && $stable(ow_ff) && $stable(os_ff)))
      else $error("stalled result changed");

endmodule

@@ rtl/shared_ring_packet_queue_top.sv @@
// Top level of the shared ring packet queue: request front end, ring engine
// and port packing.
// Depends on srpq_pkg, srpq_front and srpq_engine.
//
//   Channel  Direction  Payload
//   req_*    in         tdata = word_in[31:0]; tuser = opcode (0 write, 1 read)
//   rsp_*    out        tdata = word_out, tx_request, rx_request; tuser = status; tlast = is_last
//   csr_*    in         csr_data = queue_is_message
//
// A read fetches the header and then the packet words one after another, as
// set by the single ring memory port and its registered read, and pauses while
// the result register is stalled. The two-entry request queue registers each
// request word before the engine sees it. Reset is synchronous and resets
// indices and flags; the ring contents are not cleared. A stalled result holds
// in the output register while up to two further words are queued at the input.
module shared_ring_packet_queue_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word_in
   input  logic        req_tuser,   // [0] opcode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] word_out, [32] tx_request, [33] rx_request
   output logic [2:0]  rsp_tuser,   // [2:0] status
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_data
);

   srpq_pkg::cmd_type cmd;
   logic              cmd_valid;
   logic              cmd_pop;
   logic [31:0]       out_word;
   logic              out_tx;
   logic              out_rx;

   // Request intake and classification.
   srpq_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop)
   );

   // Ring storage and sequencing.
   srpq_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cmd_valid  (cmd_valid),
      .cmd_pop    (cmd_pop),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_word   (out_word),
      .out_last   (rsp_tlast),
      .out_status (rsp_tuser),
      .out_tx     (out_tx),
      .out_rx     (out_rx)
   );

   // The register write is always taken.
   assign csr_ready = 1'b1;
   assign rsp_tdata = {6'd0, out_rx, out_tx, out_word};

endmodule

@@ tb/srpq_checker.sv @@
`timescale 1ns / 100ps
// Response checker for the shared ring packet queue: follows the request,
// response and register channels, predicts every response word and compares.
// Depends on srpq_pkg.
module srpq_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] word_in
   input  logic        req_tuser,   // [0] opcode
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,   // [31:0] word_out, [32] tx_request, [33] rx_request
   input  logic [2:0]  rsp_tuser,   // [2:0] status
   input  logic        rsp_tlast,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic        csr_data,
   output int          mismatches,
   output int          responses_due,
   output int          responses_checked
);

   typedef struct {
      logic [31:0] word;
      logic        last;
      logic [2:0]  status;
      logic        tx;
      logic        rx;
   } response_type;

   // Expected responses, oldest first.
   response_type due_q[$];

   // Predicted queue state.
   logic [31:0]                ring_copy [srpq_pkg::RING_WORDS];
   logic [srpq_pkg::IDX_W-1:0] rd_idx;
   logic [srpq_pkg::IDX_W-1:0] wr_idx;
   logic [srpq_pkg::IDX_W-1:0] fill_idx;
   logic [srpq_pkg::IDX_W:0]   words_owed;
   logic                       discarding;
   logic                       tx_pending;
   logic                       rx_pending;
   logic                       msg_queue;

   task automatic expect_response(input logic [31:0] word, input logic last,
                                  input logic [2:0] status);
      response_type r;
      r.word   = word;
      r.last   = last;
      r.status = status;
      r.tx     = tx_pending;
      r.rx     = rx_pending;
      due_q.push_back(r);
   endtask

   // A write word either continues the packet being streamed or is a header.
   task automatic predict_write(input logic [31:0] w);
      logic [srpq_pkg::IDX_W-1:0] used;
      int unsigned                free_bytes;
      if (words_owed != 0) begin
         words_owed = words_owed - 1'b1;
         if (discarding) begin
            if (words_owed == 0)
               discarding = 1'b0;
         end else begin
            ring_copy[fill_idx] = w;
            fill_idx = fill_idx + 1'b1;
            if (words_owed == 0) begin
               wr_idx = fill_idx;
               expect_response(32'd0, 1'b1, srpq_pkg::ST_OK);
            end
         end
      end else if (w == 0 || w > srpq_pkg::RING_BYTES || w[1:0] != 2'b00) begin
         expect_response(32'd0, 1'b1, srpq_pkg::ST_INVALID);
      end else begin
         used       = wr_idx - rd_idx;
         free_bytes = srpq_pkg::RING_BYTES - 4 * used;
         words_owed = w[srpq_pkg::IDX_W+2:2] - 1'b1;
         if (free_bytes <= w) begin
            // Refused: the rest of the packet is swallowed without a response.
            tx_pending = 1'b1;
            discarding = (words_owed != 0);
            expect_response(32'd0, 1'b1, srpq_pkg::ST_NOSPACE);
         end else begin
            tx_pending = 1'b0;
            discarding = 1'b0;
            ring_copy[wr_idx] = w;
            fill_idx = wr_idx + 1'b1;
            if (words_owed == 0) begin
               wr_idx = fill_idx;
               expect_response(32'd0, 1'b1, srpq_pkg::ST_OK);
            end
         end
      end
   endtask

   // A read returns the oldest completed packet or a single status word.
   task automatic predict_read();
      logic [31:0]                size;
      logic [srpq_pkg::IDX_W-1:0] slot;
      int                         count;
      if (rd_idx == wr_idx) begin
         rx_pending = msg_queue;
         expect_response(32'd0, 1'b1, srpq_pkg::ST_EMPTY);
      end else begin
         size = ring_copy[rd_idx];
         if (size == 0) begin
            expect_response(32'd0, 1'b1, srpq_pkg::ST_INVALID);
         end else if (size > srpq_pkg::MAX_PACKET_BYTES) begin
            // Oversize packet: everything queued is thrown away.
            rd_idx     = wr_idx;
            rx_pending = msg_queue;
            expect_response(32'd0, 1'b1, srpq_pkg::ST_BADMSG);
         end else begin
            rx_pending = msg_queue;
            count = (size + 3) >> 2;
            for (int k = 0; k < count; k++) begin
               slot = rd_idx + k[srpq_pkg::IDX_W-1:0];
               expect_response(ring_copy[slot], k == count - 1, srpq_pkg::ST_OK);
            end
            rd_idx = rd_idx + count[srpq_pkg::IDX_W-1:0];
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $error("srpq_checker: %s expected %h, got %h", name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_response();
      response_type want;
      if (due_q.size() == 0) begin
         $error("srpq_checker: unexpected response word %h, status %0d",
                rsp_tdata[31:0], rsp_tuser);
         mismatches++;
      end else begin
         want = due_q.pop_front();
         compare_field("word_out", want.word, rsp_tdata[31:0]);
         compare_field("is_last", want.last, rsp_tlast);
         compare_field("status", want.status, rsp_tuser);
         compare_field("tx_request", want.tx, rsp_tdata[32]);
         compare_field("rx_request", want.rx, rsp_tdata[33]);
         responses_checked++;
      end
   endtask

   // Predict on every accepted request word, compare every accepted response.
   always @(posedge clock) begin
      if (reset) begin
         due_q.delete();
         rd_idx            = '0;
         wr_idx            = '0;
         fill_idx          = '0;
         words_owed        = '0;
         discarding        = 1'b0;
         tx_pending        = 1'b0;
         rx_pending        = 1'b1;
         msg_queue         = 1'b1;
         mismatches        = 0;
         responses_checked = 0;
      end else begin
         if (csr_valid && csr_ready)
            msg_queue = csr_data;
         if (req_tvalid && req_tready) begin
            if (req_tuser == srpq_pkg::OP_READ)
               predict_read();
            else
               predict_write(req_tdata);
         end
         if (rsp_tvalid && rsp_tready)
            check_response();
      end
      responses_due = due_q.size();
   end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench top for the shared ring packet queue: clock, reset, request and
// register stimulus, response back-pressure and the verdict.
// Depends on srpq_pkg, shared_ring_packet_queue_top and srpq_checker.
module tb_top;

   localparam int CYCLE_LIMIT  = 600000;
   // Long enough for a full-size read plus the words waiting in the input queue.
   localparam int DRAIN_CYCLES = 80;
   localparam int HOLD_CYCLES  = 400;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;   // [31:0] word_in
   logic        req_tuser  = 1'b0; // [0] opcode
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;         // [31:0] word_out, [32] tx_request, [33] rx_request
   logic [2:0]  rsp_tuser;         // [2:0] status
   logic        rsp_tlast;
   logic        csr_valid  = 1'b0;
   logic        csr_ready;
   logic        csr_data   = 1'b0;

   int mismatches;
   int responses_due;
   int responses_checked;
   int cycles      = 0;
   int words_sent  = 0;
   bit send_steady = 1'b0;
   bit sink_steady = 1'b0;
   bit hold_req    = 1'b0;

   shared_ring_packet_queue_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   srpq_checker watch (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .req_tuser         (req_tuser),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .rsp_tlast         (rsp_tlast),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_data          (csr_data),
      .mismatches        (mismatches),
      .responses_due     (responses_due),
      .responses_checked (responses_checked)
   );

   always #5 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_top: FAIL");
         $finish;
      end
   end

   // Response side: random stalls per word, plus one long hold-off on request.
   initial begin : response_sink
      int gap;
      @(negedge clock);
      forever begin
         gap = sink_steady ? 0 : $urandom_range(0, 7);
         if (hold_req) begin
            hold_req = 1'b0;
            gap      = HOLD_CYCLES;
         end
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   // Offers one request word after a random gap; returns at a falling edge.
   task automatic send_word(input logic op, input logic [31:0] word);
      int gap;
      gap = send_steady ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      words_sent++;
   endtask

   // A whole packet with random payload; reads may slip in between its words.
   task automatic send_packet(input int nwords, input int read_pct);
      send_word(srpq_pkg::OP_WRITE, nwords * 4);
      for (int k = 1; k < nwords; k++) begin
         if ($urandom_range(0, 99) < read_pct)
            send_word(srpq_pkg::OP_READ, $urandom());
         send_word(srpq_pkg::OP_WRITE, $urandom());
      end
   endtask

   // Waits until every predicted response is in and the block has gone quiet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (responses_due != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic set_message_mode(input logic value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin : stimulus
      int kind;
      int mark;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      settle();

      // Directed: header checks, single-word packet, read in the middle of a packet.
      set_message_mode(1'b1);
      send_word(srpq_pkg::OP_READ, $urandom());
      send_word(srpq_pkg::OP_WRITE, 32'd0);
      send_word(srpq_pkg::OP_WRITE, 32'd6);
      send_word(srpq_pkg::OP_WRITE, srpq_pkg::RING_BYTES + 4);
      send_word(srpq_pkg::OP_WRITE, 32'hFFFF_FFFF);
      send_word(srpq_pkg::OP_WRITE, 32'd4);
      send_word(srpq_pkg::OP_READ, 32'hFFFF_FFFF);
      send_word(srpq_pkg::OP_WRITE, 32'd12);
      send_word(srpq_pkg::OP_WRITE, 32'hFFFF_FFFF);
      send_word(srpq_pkg::OP_READ, 32'h0000_0000);
      send_word(srpq_pkg::OP_WRITE, 32'h0000_0000);
      send_word(srpq_pkg::OP_READ, $urandom());
      send_word(srpq_pkg::OP_READ, $urandom());
      settle();

      // An oversize packet at the head of the ring discards everything behind it.
      set_message_mode(1'b0);
      send_packet(srpq_pkg::MAX_PACKET_WORDS + 1, 0);
      send_packet(2, 0);
      send_word(srpq_pkg::OP_READ, $urandom());
      send_word(srpq_pkg::OP_READ, $urandom());
      settle();

      // Queue a few packets back to back, then read them with the response
      // side held off so that the input queue fills and stalls the sender.
      set_message_mode(1'b1);
      send_steady = 1'b1;
      for (int p = 0; p < 3; p++)
         send_packet(4, 0);
      send_steady = 1'b0;
      @(posedge clock);
      hold_req = 1'b1;
      @(negedge clock);
      repeat (4)
         send_word(srpq_pkg::OP_READ, $urandom());
      settle();

      // Random traffic in rounds, mostly well-formed packets mixed with reads.
      for (int round = 0; round < 4; round++) begin
         set_message_mode($urandom_range(0, 1));
         send_steady = (round == 2);
         sink_steady = (round == 3);
         mark = words_sent;
         while (words_sent < mark + 12) begin
            kind = $urandom_range(0, 99);
            if (kind < 40)
               send_packet($urandom_range(1, 16), 15);
            else if (kind < 45)
               send_packet($urandom_range(17, srpq_pkg::MAX_PACKET_WORDS + 4), 10);
            else if (kind < 80)
               send_word(srpq_pkg::OP_READ, $urandom());
            else
               case ($urandom_range(0, 2))
                  0: send_word(srpq_pkg::OP_WRITE, 32'd0);
                  1: send_word(srpq_pkg::OP_WRITE,
                               ($urandom_range(0, srpq_pkg::RING_BYTES / 4 - 1) << 2)
                               | $urandom_range(1, 3));
                  default: send_word(srpq_pkg::OP_WRITE, $urandom() | 32'h0000_1001);
               endcase
         end
         settle();
      end

      $display("Run summary: %0d request words, %0d responses checked, %0d cycles.",
               words_sent, responses_checked, cycles);
      $display("Covered bad headers, oversize discards, mid-packet reads and input stalls.");
      if (mismatches == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

@@ shared_ring_packet_queue_top.f @@
rtl/srpq_pkg.sv
rtl/srpq_front.sv
rtl/srpq_engine.sv
rtl/shared_ring_packet_queue_top.sv
tb/srpq_checker.sv
tb/tb_top.sv
